### rtl/core/evd_pkg.sv
// ----------------------------------------------------------------------------
// evd_pkg
// Shared types, codes and helpers of the event channel dispatcher.
// ----------------------------------------------------------------------------
package evd_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned SEL_WORDS = 32;
  localparam int unsigned NUM_PORTS = 1024;
  localparam int unsigned PORT_W    = 10;
  localparam int unsigned WIDX_W    = 5;
  localparam int unsigned BIDX_W    = 5;
  localparam int unsigned CNT_W     = 32;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [SEL_WORDS-1:0] sel_t;
  typedef logic [WIDX_W-1:0]    widx_t;
  typedef logic [BIDX_W-1:0]    bidx_t;
  typedef logic [PORT_W-1:0]    port_t;

  // Request action codes as they arrive on the input channel
  typedef enum logic [3:0] {
    ACT_BIND    = 4'd0,
    ACT_UNBIND  = 4'd1,
    ACT_MASK    = 4'd2,
    ACT_UNMASK  = 4'd3,
    ACT_CLRPEND = 4'd4,
    ACT_RAISE   = 4'd5,
    ACT_SERVICE = 4'd6,
    ACT_ACK     = 4'd7,
    ACT_SUSPEND = 4'd8,
    ACT_RESUME  = 4'd9
  } action_e;

  // Decoded operation handed to the back end
  typedef enum logic [3:0] {
    OP_NONE,
    OP_BIND,
    OP_UNBIND,
    OP_MASK,
    OP_UNMASK,
    OP_CLRPEND,
    OP_RAISE,
    OP_SERVICE,
    OP_ACK,
    OP_SUSPEND,
    OP_RESUME
  } op_e;

  typedef enum logic [2:0] {
    KIND_EMPTY  = 3'd0,
    KIND_NORMAL = 3'd1,
    KIND_DCALL  = 3'd2,
    KIND_IRQ    = 3'd3,
    KIND_SUSP   = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    DISP_NONE    = 3'd0,
    DISP_CALL    = 3'd1,
    DISP_IRQ     = 3'd2,
    DISP_DCALL   = 3'd3,
    DISP_SUSP    = 3'd4,
    DISP_UNBOUND = 3'd5
  } disp_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FIRE
  } state_e;

  localparam logic [1:0] BIND_TYPE_IRQ = 2'd2;

  typedef struct packed {
    logic [3:0] action;
    port_t      port;
    logic [1:0] bind_type;
    logic       auto_mask;
    logic       replace;
  } evd_in_t;

  typedef struct packed {
    logic             status;
    port_t            fired_port;
    logic [2:0]       dispatch;
    logic [CNT_W-1:0] fire_count;
    logic             scan_done;
    logic             handled;
    logic             was_pending;
    logic             all_acked;
  } evd_out_t;

  typedef struct packed {
    op_e        op;
    port_t      port;
    logic [1:0] bind_type;
    logic       auto_mask;
    logic       replace;
  } cmd_t;

  // One port table entry
  typedef struct packed {
    kind_e            kind;
    logic             fire_mask;
    logic [CNT_W-1:0] count;
  } ent_t;

  typedef struct packed {
    port_t rd_addr;
    logic  wr_en;
    port_t wr_addr;
    ent_t  wr_data;
  } tab_req_t;

  // Lowest set bit of a word (zero when empty)
  function automatic bidx_t ffs(input word_t v);
    bidx_t r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) r = bidx_t'(i);
    end
    return r;
  endfunction

endpackage

### rtl/core/event_channel_dispatcher.sv
// An accepted request passes the front queue and the command register into
//   the result register; a scanning service request first steps through the
//   set selector words, then ends the scan or dispatches (scan hit, then port
//   table read-modify-write). The back end takes a request only from idle, so
//   a new request waits until the last is done. Reset: asynchronous; then a
//   port table clearing pass during which no request is accepted.
// ----------------------------------------------------------------------------
// event_channel_dispatcher
// Two-level pending bitmap event dispatcher: front decode queue, back
// execution engine and per-port table.
// ----------------------------------------------------------------------------
module event_channel_dispatcher (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  evd_pkg::evd_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output evd_pkg::evd_out_t out_data_o
);

  evd_pkg::cmd_t     cmd;
  logic              cmd_valid, pop, tab_busy;
  evd_pkg::tab_req_t tab_req;
  evd_pkg::ent_t     tab_rd;

  evd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .busy_i      (tab_busy),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .pop_i       (pop)
  );

  evd_ptab u_ptab (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (tab_req),
    .rd_data_o (tab_rd),
    .busy_o    (tab_busy)
  );

  evd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .pop_o       (pop),
    .tab_req_o   (tab_req),
    .tab_rd_i    (tab_rd),
    .tab_busy_i  (tab_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### rtl/core/evd_front.sv
// ----------------------------------------------------------------------------
// evd_front
// Accepts requests, decodes the action and queues them for the back end.
// ----------------------------------------------------------------------------
module evd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  evd_pkg::evd_in_t in_data_i,
  input  logic             busy_i,
  output logic             cmd_valid_o,
  output evd_pkg::cmd_t    cmd_o,
  input  logic             pop_i
);

  evd_pkg::cmd_t fifo_q [2];
  evd_pkg::cmd_t cmd_dec;
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;
  logic          push;

  // Action decode, unknown codes become no-ops
  always_comb begin
    cmd_dec.port      = in_data_i.port;
    cmd_dec.bind_type = in_data_i.bind_type;
    cmd_dec.auto_mask = in_data_i.auto_mask;
    cmd_dec.replace   = in_data_i.replace;
    case (evd_pkg::action_e'(in_data_i.action))
      evd_pkg::ACT_BIND:    cmd_dec.op = evd_pkg::OP_BIND;
      evd_pkg::ACT_UNBIND:  cmd_dec.op = evd_pkg::OP_UNBIND;
      evd_pkg::ACT_MASK:    cmd_dec.op = evd_pkg::OP_MASK;
      evd_pkg::ACT_UNMASK:  cmd_dec.op = evd_pkg::OP_UNMASK;
      evd_pkg::ACT_CLRPEND: cmd_dec.op = evd_pkg::OP_CLRPEND;
      evd_pkg::ACT_RAISE:   cmd_dec.op = evd_pkg::OP_RAISE;
      evd_pkg::ACT_SERVICE: cmd_dec.op = evd_pkg::OP_SERVICE;
      evd_pkg::ACT_ACK:     cmd_dec.op = evd_pkg::OP_ACK;
      evd_pkg::ACT_SUSPEND: cmd_dec.op = evd_pkg::OP_SUSPEND;
      evd_pkg::ACT_RESUME:  cmd_dec.op = evd_pkg::OP_RESUME;
      default:              cmd_dec.op = evd_pkg::OP_NONE;
    endcase
  end

  // Two-entry request queue; closed while the port table initialises
  assign in_stall_o  = (cnt_q == 2'd2) || busy_i;
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= cmd_dec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

endmodule

### rtl/core/evd_ptab.sv
// ----------------------------------------------------------------------------
// evd_ptab
// Per-port table (binding kind, mask-on-fire, event count) with an
// initialisation sweep after reset.
// ----------------------------------------------------------------------------
module evd_ptab (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  evd_pkg::tab_req_t  req_i,
  output evd_pkg::ent_t      rd_data_o,
  output logic               busy_o
);

  evd_pkg::ent_t     mem [evd_pkg::NUM_PORTS];
  evd_pkg::port_t    clr_q;
  logic              busy_q;

  // Clearing sweep, one entry a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      clr_q <= clr_q + evd_pkg::port_t'(1);
      if (clr_q == evd_pkg::port_t'(evd_pkg::NUM_PORTS - 1)) busy_q <= 1'b0;
    end
  end

  // Single write port, registered read
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_q] <= '0;
    end else if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    rd_data_o <= mem[req_i.rd_addr];
  end

  assign busy_o = busy_q;

endmodule

### rtl/core/evd_back.sv
// ----------------------------------------------------------------------------
// evd_back
// Executes queued requests: bitmap updates, service scan and dispatch,
// and holds the result register.
// ----------------------------------------------------------------------------
module evd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  evd_pkg::cmd_t     cmd_i,
  output logic              pop_o,
  output evd_pkg::tab_req_t tab_req_o,
  input  evd_pkg::ent_t     tab_rd_i,
  input  logic              tab_busy_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output evd_pkg::evd_out_t out_data_o
);

  evd_pkg::state_e   state_q, state_d;
  evd_pkg::cmd_t     cmd_q;
  evd_pkg::word_t    pend_q [evd_pkg::SEL_WORDS];
  evd_pkg::word_t    pend_d [evd_pkg::SEL_WORDS];
  evd_pkg::word_t    mask_q [evd_pkg::SEL_WORDS];
  evd_pkg::word_t    mask_d [evd_pkg::SEL_WORDS];
  evd_pkg::word_t    priv_q [evd_pkg::SEL_WORDS];
  evd_pkg::word_t    priv_d [evd_pkg::SEL_WORDS];
  evd_pkg::word_t    irq_q  [evd_pkg::SEL_WORDS];
  evd_pkg::word_t    irq_d  [evd_pkg::SEL_WORDS];
  evd_pkg::sel_t     privnz_q, privnz_d;
  evd_pkg::sel_t     sel_q, sel_d;
  evd_pkg::sel_t     swords_q, swords_d;
  logic              doff_q, doff_d;
  logic              act_q, act_d;
  logic              sh_q, sh_d;
  logic              sd_q, sd_d;
  evd_pkg::port_t    fp_q, fp_d;
  evd_pkg::evd_out_t out_q, res;
  logic              out_valid_q;
  logic              emit, out_free, svc_scan;
  evd_pkg::widx_t    cw, sw, fw;
  evd_pkg::bidx_t    cb, sb, fb;
  evd_pkg::word_t    cbit, fbit, slive;
  logic [evd_pkg::CNT_W-1:0] cnt_inc;

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = (state_q == evd_pkg::ST_IDLE) && cmd_valid_i && out_free && !tab_busy_i;
  assign cw       = cmd_q.port[evd_pkg::PORT_W-1:evd_pkg::BIDX_W];
  assign cb       = cmd_q.port[evd_pkg::BIDX_W-1:0];
  assign cbit     = evd_pkg::word_t'(1) << cb;
  assign sw       = evd_pkg::widx_t'(evd_pkg::ffs(swords_q));
  assign slive    = pend_q[sw] & ~mask_q[sw];
  assign sb       = evd_pkg::ffs(slive);
  assign fw       = fp_q[evd_pkg::PORT_W-1:evd_pkg::BIDX_W];
  assign fb       = fp_q[evd_pkg::BIDX_W-1:0];
  assign fbit     = evd_pkg::word_t'(1) << fb;
  assign svc_scan = act_q || !doff_q;
  assign cnt_inc  = tab_rd_i.count + evd_pkg::CNT_W'(1);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      evd_pkg::ST_IDLE: if (pop_o) state_d = evd_pkg::ST_EXEC;
      evd_pkg::ST_EXEC: begin
        if (cmd_q.op == evd_pkg::OP_SERVICE && svc_scan) state_d = evd_pkg::ST_SCAN;
        else state_d = evd_pkg::ST_IDLE;
      end
      evd_pkg::ST_SCAN: begin
        if (swords_q == '0) state_d = evd_pkg::ST_IDLE;
        else if (slive != '0) state_d = evd_pkg::ST_FIRE;
      end
      evd_pkg::ST_FIRE: state_d = evd_pkg::ST_IDLE;
      default:          state_d = evd_pkg::ST_IDLE;
    endcase
  end

  // Datapath and result
  always_comb begin
    pend_d    = pend_q;
    mask_d    = mask_q;
    priv_d    = priv_q;
    irq_d     = irq_q;
    privnz_d  = privnz_q;
    sel_d     = sel_q;
    swords_d  = swords_q;
    doff_d    = doff_q;
    act_d     = act_q;
    sh_d      = sh_q;
    sd_d      = sd_q;
    fp_d      = fp_q;
    res       = '0;
    emit      = 1'b0;
    tab_req_o = '0;
    tab_req_o.rd_addr = cmd_i.port;

    case (state_q)
      evd_pkg::ST_IDLE: ;
      evd_pkg::ST_EXEC: begin
        emit = 1'b1;
        tab_req_o.wr_addr = cmd_q.port;
        case (cmd_q.op)
          evd_pkg::OP_BIND: begin
            if (tab_rd_i.kind != evd_pkg::KIND_EMPTY && !cmd_q.replace) begin
              res.status = 1'b1;
            end else begin
              tab_req_o.wr_en             = 1'b1;
              tab_req_o.wr_data.kind      = evd_pkg::kind_e'({1'b0, cmd_q.bind_type} + 3'd1);
              tab_req_o.wr_data.fire_mask = cmd_q.auto_mask;
              tab_req_o.wr_data.count     = tab_rd_i.count;
              mask_d[cw][cb] = 1'b0;
              irq_d[cw][cb]  = (cmd_q.bind_type == evd_pkg::BIND_TYPE_IRQ);
            end
          end
          evd_pkg::OP_UNBIND: begin
            tab_req_o.wr_en             = 1'b1;
            tab_req_o.wr_data.kind      = evd_pkg::KIND_EMPTY;
            tab_req_o.wr_data.fire_mask = tab_rd_i.fire_mask;
            tab_req_o.wr_data.count     = tab_rd_i.count;
            mask_d[cw][cb] = 1'b1;
            irq_d[cw][cb]  = 1'b0;
          end
          evd_pkg::OP_MASK:    mask_d[cw][cb] = 1'b1;
          evd_pkg::OP_UNMASK:  mask_d[cw][cb] = 1'b0;
          evd_pkg::OP_CLRPEND: pend_d[cw][cb] = 1'b0;
          evd_pkg::OP_RAISE: begin
            pend_d[cw][cb] = 1'b1;
            if (!mask_q[cw][cb]) sel_d[cw] = 1'b1;
          end
          evd_pkg::OP_ACK: begin
            res.was_pending = priv_q[cw][cb];
            priv_d[cw]      = priv_q[cw] & ~cbit;
            privnz_d[cw]    = |(priv_q[cw] & ~cbit);
            res.all_acked   = ~|privnz_d;
          end
          evd_pkg::OP_SUSPEND: doff_d = 1'b1;
          evd_pkg::OP_RESUME:  doff_d = 1'b0;
          evd_pkg::OP_SERVICE: begin
            // Scan start: drop private pending, snapshot the selector unless suspended
            if (!act_q) begin
              for (int i = 0; i < evd_pkg::SEL_WORDS; i++) priv_d[i] = '0;
              privnz_d = '0;
              if (doff_q) begin
                res.scan_done = 1'b1;
                res.handled   = 1'b1;
              end else begin
                swords_d = sel_q;
                sel_d    = '0;
                act_d    = 1'b1;
                sh_d     = 1'b0;
                sd_d     = 1'b0;
              end
            end
            if (svc_scan) emit = 1'b0;
          end
          default: ;
        endcase
      end
      evd_pkg::ST_SCAN: begin
        // One selector word per cycle
        if (swords_q == '0) begin
          act_d         = 1'b0;
          emit          = 1'b1;
          res.scan_done = 1'b1;
          res.handled   = sh_q && !sd_q;
        end else if (slive == '0) begin
          swords_d[sw] = 1'b0;
        end else begin
          pend_d[sw][sb]    = 1'b0;
          sh_d              = 1'b1;
          fp_d              = {sw, sb};
          tab_req_o.rd_addr = {sw, sb};
        end
      end
      evd_pkg::ST_FIRE: begin
        emit                        = 1'b1;
        tab_req_o.wr_en             = 1'b1;
        tab_req_o.wr_addr           = fp_q;
        tab_req_o.wr_data.kind      = tab_rd_i.kind;
        tab_req_o.wr_data.fire_mask = tab_rd_i.fire_mask;
        tab_req_o.wr_data.count     = cnt_inc;
        if (tab_rd_i.fire_mask) mask_d[fw] = mask_q[fw] | fbit;
        res.fired_port = fp_q;
        res.fire_count = cnt_inc;
        case (tab_rd_i.kind)
          evd_pkg::KIND_NORMAL: res.dispatch = evd_pkg::DISP_CALL;
          evd_pkg::KIND_DCALL:  res.dispatch = evd_pkg::DISP_DCALL;
          evd_pkg::KIND_IRQ: begin
            res.dispatch = evd_pkg::DISP_IRQ;
            priv_d[fw]   = priv_q[fw] | fbit;
            privnz_d[fw] = 1'b1;
            sd_d         = 1'b1;
          end
          evd_pkg::KIND_SUSP: begin
            // Mark every irq-bound port privately pending
            res.dispatch = evd_pkg::DISP_SUSP;
            for (int i = 0; i < evd_pkg::SEL_WORDS; i++) begin
              priv_d[i]   = priv_q[i] | irq_q[i];
              privnz_d[i] = |(priv_q[i] | irq_q[i]);
            end
            sd_d = 1'b1;
          end
          default: res.dispatch = evd_pkg::DISP_UNBOUND;
        endcase
      end
      default: ;
    endcase
  end

  // Command and result registers
  always_ff @(posedge clk_i) begin
    if (pop_o) cmd_q <= cmd_i;
    if (emit) out_q <= res;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= evd_pkg::ST_IDLE;
      for (int i = 0; i < evd_pkg::SEL_WORDS; i++) begin
        pend_q[i] <= '0;
        mask_q[i] <= '1;
        priv_q[i] <= '0;
        irq_q[i]  <= '0;
      end
      privnz_q    <= '0;
      sel_q       <= '0;
      swords_q    <= '0;
      doff_q      <= 1'b0;
      act_q       <= 1'b0;
      sh_q        <= 1'b0;
      sd_q        <= 1'b0;
      fp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pend_q   <= pend_d;
      mask_q   <= mask_d;
      priv_q   <= priv_d;
      irq_q    <= irq_d;
      privnz_q <= privnz_d;
      sel_q    <= sel_d;
      swords_q <= swords_d;
      doff_q   <= doff_d;
      act_q    <= act_d;
      sh_q     <= sh_d;
      sd_q     <= sd_d;
      fp_q     <= fp_d;
      if (emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A result is only produced into an empty output register
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> !out_valid_q) else $error("result overwrites pending output");

  // A dispatch always follows a successful scan step
  a_fire_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == evd_pkg::ST_FIRE) |-> ($past(state_q) == evd_pkg::ST_SCAN && act_q))
    else $error("fire outside a scan");

  // No request is taken while the port table initialises
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tab_busy_i |-> (!pop_o && state_q == evd_pkg::ST_IDLE))
    else $error("request taken during table clear");

endmodule
